@@ rtl/abl_pkg.sv @@
// ============================================================================
// abl_pkg: shared types and codes for the address blocklist table
//
// Holds the operation codes, the request and response transaction types,
// and the control structs that the table drives into its row of cells.
// ============================================================================
package abl_pkg;

   // Operation codes carried in the kind field of a request.
   localparam logic [1:0] KIND_LOOKUP = 2'd0;
   localparam logic [1:0] KIND_ADD    = 2'd1;
   localparam logic [1:0] KIND_REMOVE = 2'd2;
   localparam logic [1:0] KIND_CLEAR  = 2'd3;

   localparam int ADDR_W  = 32;
   localparam int POS_W   = 6;
   localparam int COUNT_W = 7;

   // One request transaction.
   typedef struct packed {
      logic [1:0]        kind;
      logic [ADDR_W-1:0] address;
   } req_type;

   // One response transaction.
   typedef struct packed {
      logic               ok;
      logic               found;
      logic [POS_W-1:0]   position;
      logic [COUNT_W-1:0] entry_count;
      logic               table_full;
   } rsp_type;

   // Commands broadcast to every cell in the row.
   typedef struct packed {
      logic              capture;  // register the compare result
      logic [ADDR_W-1:0] cmp_addr; // address compared against each entry
      logic              append;   // write wr_addr into the tail cell
      logic              shift;    // cells at or above the hit take the next entry
      logic [ADDR_W-1:0] wr_addr;  // address appended on an add
   } cell_ctl_type;

   // Per-cell position flags, derived from the count and the hit index.
   typedef struct packed {
      logic live;   // the cell holds a valid entry
      logic tail;   // the cell is the first free slot
      logic above;  // the cell sits at or above the removed entry
   } cell_sel_type;

endpackage

@@ rtl/abl_cell.sv @@
// ============================================================================
// abl_cell: one slot of the address blocklist table
//
// Holds one 32-bit entry, compares it against the broadcast address, takes
// an appended address when it is the tail slot, and takes its upper
// neighbor's entry when a remove closes the gap.
// ============================================================================
module abl_cell (
   input  logic                                clock,
   input  logic                                reset,
   input  abl_pkg::cell_ctl_type               ctl,
   input  abl_pkg::cell_sel_type               sel,
   input  logic [abl_pkg::ADDR_W-1:0]          entry_next,
   output logic [abl_pkg::ADDR_W-1:0]          entry,
   output logic                                match
);

   logic [abl_pkg::ADDR_W-1:0] entry_ff;
   logic [abl_pkg::ADDR_W-1:0] entry_in;
   logic                       match_ff;
   logic                       match_in;

   // Compare result for the incoming transaction. Address zero never matches.
   always_comb begin
      match_in = match_ff;
      if (ctl.capture) begin
         match_in = sel.live && (entry_ff == ctl.cmp_addr) && (ctl.cmp_addr != '0);
      end
   end

   // Entry update: append at the tail, or shift down on a remove.
   always_comb begin
      entry_in = entry_ff;
      if (ctl.append && sel.tail) begin
         entry_in = ctl.wr_addr;
      end else if (ctl.shift && sel.above) begin
         entry_in = entry_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         match_ff <= 1'b0;
      end else begin
         match_ff <= match_in;
      end
   end

   // The entry store carries no reset; slots beyond the count are never read.
   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;
   assign match = match_ff;

endmodule

@@ rtl/address_blocklist_table.sv @@
// ============================================================================
// address_blocklist_table: ordered table of blocked IPv4 addresses
//
// Channel     Direction  Ports                    Handshake
// request     in         start, busy, req_data    taken when start and !busy
// response    out        rsp_strobe, rsp_data     valid for one cycle, no stall
//
// At the accepting edge every cell compares its entry against the address
// in parallel and registers a hit bit; in the apply state that comes after,
// the hit index is encoded, the row is updated (append at the tail or shift
// down to close a gap) and the response is registered. busy is high in the
// apply state, so no new transaction is accepted until the held one has
// been applied. rsp_strobe marks the response in the cycle after the
// update. Reset clears the count and the control state; the entries
// themselves need no clearing.
// ============================================================================
module address_blocklist_table #(
   parameter int CAPACITY = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  abl_pkg::req_type req_data,
   output logic             rsp_strobe,
   output abl_pkg::rsp_type rsp_data
);

   localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W = $clog2(CAPACITY + 1);

   // Sequencer state codes.
   localparam logic ST_IDLE  = 1'b0;
   localparam logic ST_APPLY = 1'b1;

   logic                       state_ff;
   logic                       state_in;
   logic [CNT_W-1:0]           count_ff;
   logic [CNT_W-1:0]           count_in;
   abl_pkg::req_type           req_ff;
   abl_pkg::rsp_type           rsp_ff;
   abl_pkg::rsp_type           rsp_in;
   logic                       strobe_ff;
   logic                       strobe_in;

   logic                       accept;
   logic                       apply;
   logic [CAPACITY-1:0]        match;
   logic [abl_pkg::ADDR_W-1:0] entry    [CAPACITY];
   logic                       hit;
   logic [IDX_W-1:0]           hit_pos;
   abl_pkg::cell_ctl_type      ctl;
   logic                       do_append;
   logic                       do_shift;
   logic [31:0]                pos_wide;
   logic [31:0]                count_wide;

   assign accept = start && (state_ff == ST_IDLE);
   assign apply  = (state_ff == ST_APPLY);
   assign busy   = apply;

   // Hit encoding: entries are unique, so at most one cell matches.
   always_comb begin
      hit_pos = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         if (match[i]) begin
            hit_pos = hit_pos | IDX_W'(i);
         end
      end
   end
   assign hit = |match;

   // Operation decode and response for the held transaction.
   always_comb begin
      count_in  = count_ff;
      do_append = 1'b0;
      do_shift  = 1'b0;
      rsp_in    = '0;
      if (apply) begin
         case (req_ff.kind)
            abl_pkg::KIND_CLEAR: begin
               count_in  = '0;
               rsp_in.ok = 1'b1;
            end
            abl_pkg::KIND_LOOKUP: begin
               rsp_in.ok    = (req_ff.address != '0);
               rsp_in.found = hit;
            end
            abl_pkg::KIND_ADD: begin
               if (req_ff.address == '0) begin
                  rsp_in.ok = 1'b0;
               end else if (hit) begin
                  rsp_in.ok    = 1'b1;
                  rsp_in.found = 1'b1;
               end else if (count_ff == CNT_W'(CAPACITY)) begin
                  rsp_in.table_full = 1'b1;
               end else begin
                  do_append = 1'b1;
                  count_in  = count_ff + 1'b1;
                  rsp_in.ok = 1'b1;
               end
            end
            abl_pkg::KIND_REMOVE: begin
               rsp_in.ok = (req_ff.address != '0);
               if (hit) begin
                  rsp_in.found = 1'b1;
                  do_shift     = 1'b1;
                  count_in     = count_ff - 1'b1;
               end
            end
            default: begin
               rsp_in = '0;
            end
         endcase
      end
      pos_wide           = 32'(hit_pos);
      count_wide         = 32'(count_in);
      rsp_in.position    = rsp_in.found ? pos_wide[abl_pkg::POS_W-1:0] : '0;
      rsp_in.entry_count = count_wide[abl_pkg::COUNT_W-1:0];
   end

   // Commands broadcast to the row of cells.
   always_comb begin
      ctl.capture  = accept;
      ctl.cmp_addr = req_data.address;
      ctl.append   = do_append;
      ctl.shift    = do_shift;
      ctl.wr_addr  = req_ff.address;
   end

   // Row of cells; each one hands its entry down to the cell below it.
   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      abl_pkg::cell_sel_type      sel;
      logic [abl_pkg::ADDR_W-1:0] entry_next;

      assign sel.live  = (CNT_W'(g) < count_ff);
      assign sel.tail  = (CNT_W'(g) == count_ff);
      assign sel.above = (IDX_W'(g) >= hit_pos);

      if (g == CAPACITY - 1) begin : g_last
         assign entry_next = entry[g];
      end else begin : g_mid
         assign entry_next = entry[g+1];
      end

      abl_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctl        (ctl),
         .sel        (sel),
         .entry_next (entry_next),
         .entry      (entry[g]),
         .match      (match[g])
      );
   end

   assign state_in  = accept ? ST_APPLY : ST_IDLE;
   assign strobe_in = apply;

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         count_ff  <= '0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         strobe_ff <= strobe_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff <= req_data;
      end
      if (apply) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_data   = rsp_ff;

   // A response only follows a cycle in which the update was applied.
   a_rsp_after_apply: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(busy))
      else $error("response without a preceding update cycle");

   // Entries are unique, so no more than one cell may hit.
   a_single_hit: assert property (@(posedge clock) disable iff (reset)
      $onehot0(match))
      else $error("more than one cell matched the address");

   // The count never exceeds the table capacity.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("entry count beyond capacity");

   // An accepted transaction is applied in the next cycle.
   a_accept_apply: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy)
      else $error("accepted transaction not applied");

   // A refused add never reports success.
   a_full_not_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.table_full) |-> !rsp_data.ok)
      else $error("full table reported together with success");

endmodule

@@ dv/tb_address_blocklist_table.sv @@
// ============================================================================
// tb_address_blocklist_table: self-checking bench for the blocklist table
//
// A queue of operations is filled by the sequencing block. The driver
// presents each operation on start/req_data at the falling edge. Every
// transaction taken at a rising edge is run through a behavioral copy of
// the table, and the predicted response is queued. The monitor compares
// each strobed response, field by field, with the oldest prediction.
// Directed corner cases come first. Random traffic follows, drawn from
// small address pools so that hits, removals and duplicates are common.
// Two runs fill the table past its capacity. The sender idles at
// several rates, and the bench drains between phases.
// ============================================================================
module tb_address_blocklist_table;

   localparam int TABLE_DEPTH    = 64;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int REPORT_LIMIT   = 200;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             start = 1'b0;
   logic             busy;
   abl_pkg::req_type req_data = '0;
   logic             rsp_strobe;
   abl_pkg::rsp_type rsp_data;

   // Operations waiting to be driven, and responses still owed by the block.
   abl_pkg::req_type queued_ops[$];
   abl_pkg::rsp_type owed_answers[$];

   // Behavioral copy of the table contents.
   logic [abl_pkg::ADDR_W-1:0] held_addrs[TABLE_DEPTH];
   int                         held_count = 0;

   // Address pool that random traffic draws from.
   logic [abl_pkg::ADDR_W-1:0] addr_pool[$];

   int   idle_pct     = 0;
   int   mismatches   = 0;
   int   quiet_cycles = 0;
   logic took_item    = 1'b0;

   address_blocklist_table #(
      .CAPACITY(TABLE_DEPTH)
   ) u_top (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_strobe(rsp_strobe),
      .rsp_data  (rsp_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Apply one operation to the behavioral table and return its response.
   function automatic abl_pkg::rsp_type blocklist_apply(abl_pkg::req_type op);
      abl_pkg::rsp_type answer;
      int               hit;
      answer = '0;
      hit    = -1;
      if (op.kind != abl_pkg::KIND_CLEAR && op.address != '0) begin
         for (int i = 0; i < held_count; i++) begin
            if (hit < 0 && held_addrs[i] == op.address) hit = i;
         end
      end
      if (op.kind == abl_pkg::KIND_CLEAR) begin
         held_count = 0;
         answer.ok  = 1'b1;
      end else if (op.address == '0) begin
         // A zero address is refused by every operation but a clear.
         answer.ok = 1'b0;
      end else if (hit >= 0) begin
         answer.ok       = 1'b1;
         answer.found    = 1'b1;
         answer.position = abl_pkg::POS_W'(hit);
         if (op.kind == abl_pkg::KIND_REMOVE) begin
            for (int i = hit; i < held_count - 1; i++) held_addrs[i] = held_addrs[i + 1];
            held_count--;
         end
      end else if (op.kind == abl_pkg::KIND_ADD) begin
         if (held_count >= TABLE_DEPTH) begin
            answer.table_full = 1'b1;
         end else begin
            held_addrs[held_count] = op.address;
            held_count++;
            answer.ok = 1'b1;
         end
      end else begin
         // A lookup miss or the removal of an absent address still succeeds.
         answer.ok = 1'b1;
      end
      answer.entry_count = abl_pkg::COUNT_W'(held_count);
      return answer;
   endfunction

   task automatic check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         mismatches++;
         if (mismatches <= REPORT_LIMIT)
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
      end
   endtask

   // Driver: offer the next operation once the previous one has been taken.
   always @(negedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (!start || took_item) begin
         if (queued_ops.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
            start    <= 1'b1;
            req_data <= queued_ops.pop_front();
         end else begin
            start <= 1'b0;
         end
      end
   end

   // Monitor, predictor and watchdog, all sampled at the rising edge.
   always @(posedge clock) begin
      abl_pkg::rsp_type want;
      if (reset) begin
         took_item    <= 1'b0;
         quiet_cycles <= 0;
      end else begin
         if (rsp_strobe) begin
            if (owed_answers.size() == 0) begin
               mismatches++;
               if (mismatches <= REPORT_LIMIT)
                  $display("%0t: unexpected response, expected none actual %0h",
                           $time, rsp_data);
            end else begin
               want = owed_answers.pop_front();
               check_field("ok", want.ok, rsp_data.ok);
               check_field("found", want.found, rsp_data.found);
               check_field("position", want.position, rsp_data.position);
               check_field("entry_count", want.entry_count, rsp_data.entry_count);
               check_field("table_full", want.table_full, rsp_data.table_full);
            end
         end
         if (start && !busy)
            owed_answers.insert(owed_answers.size(), blocklist_apply(req_data));
         took_item <= start && !busy;
         if ((start && !busy) || rsp_strobe) begin
            quiet_cycles <= 0;
         end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("status: fail");
            $finish;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   task automatic queue_op(logic [1:0] kind, logic [abl_pkg::ADDR_W-1:0] address);
      abl_pkg::req_type op;
      op.kind    = kind;
      op.address = address;
      queued_ops.insert(queued_ops.size(), op);
   endtask

   function automatic logic [abl_pkg::ADDR_W-1:0] nonzero_addr();
      logic [abl_pkg::ADDR_W-1:0] a;
      do a = $urandom; while (a == '0);
      return a;
   endfunction

   task automatic make_pool(int size);
      addr_pool.delete();
      repeat (size) addr_pool.insert(addr_pool.size(), nonzero_addr());
   endtask

   // Random operations, mostly on pool addresses, with some zero and stray ones.
   task automatic random_ops(int n);
      logic [1:0]                 addr_kinds[3];
      int                         r;
      logic [abl_pkg::ADDR_W-1:0] pick;
      addr_kinds = '{abl_pkg::KIND_LOOKUP, abl_pkg::KIND_ADD, abl_pkg::KIND_REMOVE};
      repeat (n) begin
         r    = $urandom_range(0, 99);
         pick = addr_pool[$urandom_range(0, addr_pool.size() - 1)];
         if (r < 4)       queue_op(addr_kinds[$urandom_range(0, 2)], '0);
         else if (r < 6)  queue_op(abl_pkg::KIND_CLEAR, $urandom);
         else if (r < 50) queue_op(abl_pkg::KIND_ADD, pick);
         else if (r < 72) queue_op(abl_pkg::KIND_LOOKUP, pick);
         else if (r < 75) queue_op(abl_pkg::KIND_LOOKUP, $urandom);
         else if (r < 97) queue_op(abl_pkg::KIND_REMOVE, pick);
         else             queue_op(abl_pkg::KIND_REMOVE, $urandom);
      end
   endtask

   task automatic random_bursts(int n);
      int chunk;
      while (n > 0) begin
         chunk = (n < 30) ? n : 30;
         make_pool($urandom_range(1, 40));
         random_ops(chunk);
         n -= chunk;
      end
   endtask

   // Fill the table past capacity, then churn on the same addresses.
   task automatic fill_run();
      queue_op(abl_pkg::KIND_CLEAR, '0);
      make_pool(TABLE_DEPTH + 6);
      foreach (addr_pool[i]) queue_op(abl_pkg::KIND_ADD, addr_pool[i]);
      random_ops(40);
   endtask

   // Hold back further traffic until every owed response has arrived.
   // Checked at the rising edge, where start is stable.
   task automatic drain();
      do @(posedge clock);
      while (queued_ops.size() != 0 || start || owed_answers.size() != 0);
   endtask

   // Sequencing: directed cases, then random phases at several idle rates.
   initial begin
      repeat (5) @(negedge clock);
      reset <= 1'b0;

      queue_op(abl_pkg::KIND_LOOKUP, '0);
      queue_op(abl_pkg::KIND_ADD, '0);
      queue_op(abl_pkg::KIND_REMOVE, '0);
      queue_op(abl_pkg::KIND_LOOKUP, 32'h0000_0001);
      queue_op(abl_pkg::KIND_REMOVE, 32'hFFFF_FFFF);
      queue_op(abl_pkg::KIND_ADD, 32'hFFFF_FFFF);
      queue_op(abl_pkg::KIND_ADD, 32'h0000_0001);
      queue_op(abl_pkg::KIND_ADD, 32'h8000_0000);
      queue_op(abl_pkg::KIND_ADD, 32'h0000_0001);
      queue_op(abl_pkg::KIND_LOOKUP, 32'h8000_0000);
      queue_op(abl_pkg::KIND_REMOVE, 32'h1234_5678);
      queue_op(abl_pkg::KIND_REMOVE, 32'hFFFF_FFFF);
      queue_op(abl_pkg::KIND_LOOKUP, 32'h0000_0001);
      queue_op(abl_pkg::KIND_LOOKUP, 32'hFFFF_FFFF);
      queue_op(abl_pkg::KIND_ADD, 32'hA5A5_A5A5);
      queue_op(abl_pkg::KIND_ADD, 32'h5A5A_5A5A);
      queue_op(abl_pkg::KIND_CLEAR, 32'hDEAD_BEEF);
      queue_op(abl_pkg::KIND_LOOKUP, 32'h0000_0001);
      queue_op(abl_pkg::KIND_ADD, 32'h0000_0001);
      queue_op(abl_pkg::KIND_CLEAR, '0);
      drain();

      idle_pct = 0;
      fill_run();
      random_bursts(80);
      drain();

      idle_pct = 74;
      random_bursts(180);
      drain();

      idle_pct = 28;
      fill_run();
      random_bursts(70);
      drain();

      idle_pct = 0;
      random_bursts(180);
      drain();

      repeat (8) @(negedge clock);
      if (mismatches == 0 && owed_answers.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
